/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, sampled on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge
`define NTFP_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// ante implies cons in the same cycle
`define NTFP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// ante implies cons in the next cycle
`define NTFP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ntfp_pkg.sv */
// ----------------------------------------------------------------------------
// ntfp_pkg
// Widths, register map, command codes and shared types of the frame pairer.
// ----------------------------------------------------------------------------
package ntfp_pkg;

  localparam int TS_W     = 64;
  localparam int TAG_IN_W = 16;
  localparam int DELTA_W  = 33;
  localparam int THR_W    = 32;
  localparam int LIM_W    = 4;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int TAG_BITS_DEF    = 16;

  localparam logic [THR_W-1:0] THR_RESET = 32'd20000000;
  localparam logic [LIM_W-1:0] LIM_RESET = 4'd8;

  // register index = paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_LIMIT     = 1'b1;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  localparam int S_TUSER_W = 2;
  localparam int S_TDATA_W = ((TS_W + TAG_IN_W + 7) / 8) * 8;
  localparam int RES_W     = 2 * TS_W + 2 * TAG_IN_W + DELTA_W;
  localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [LIM_W-1:0] limit;
  } ntfp_cfg_t;

  typedef struct packed {
    logic signed [DELTA_W-1:0] delta;
    logic [TAG_IN_W-1:0]       dep_tag;
    logic [TS_W-1:0]           dep_ts;
    logic [TAG_IN_W-1:0]       rgb_tag;
    logic [TS_W-1:0]           rgb_ts;
  } ntfp_res_t;

endpackage

/* rtl/core/ntfp_ram.sv */
// ----------------------------------------------------------------------------
// ntfp_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ntfp_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/ntfp_gap_unit.sv */
// ----------------------------------------------------------------------------
// ntfp_gap_unit
// Shared timestamp distance unit: registered |a - b| and a >= b flag.
// ----------------------------------------------------------------------------
module ntfp_gap_unit (
  input  logic                    clk_i,
  input  logic [ntfp_pkg::TS_W-1:0] a_i,
  input  logic [ntfp_pkg::TS_W-1:0] b_i,
  output logic [ntfp_pkg::TS_W-1:0] gap_o,
  output logic                    a_ge_b_o
);
  import ntfp_pkg::*;

  logic [TS_W:0]   diff_ab;
  logic [TS_W-1:0] diff_ba;
  logic [TS_W-1:0] gap_q;
  logic            ge_q;

  assign diff_ab = {1'b0, a_i} - {1'b0, b_i};
  assign diff_ba = b_i - a_i;

  always_ff @(posedge clk_i) begin
    ge_q  <= ~diff_ab[TS_W];
    gap_q <= diff_ab[TS_W] ? diff_ba : diff_ab[TS_W-1:0];
  end

  assign gap_o    = gap_q;
  assign a_ge_b_o = ge_q;

endmodule

/* rtl/core/ntfp_seq.sv */
// ----------------------------------------------------------------------------
// ntfp_seq
// Queue sequencer: append/trim, nearest-entry scan, pair emit, queue compaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntfp_seq #(
  parameter int QUEUE_DEPTH = ntfp_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = ntfp_pkg::TAG_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ntfp_pkg::ntfp_cfg_t           cfg_i,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic                          s_cmd_i,
  input  logic                          s_is_depth_i,
  input  logic [ntfp_pkg::TS_W-1:0]     s_ts_i,
  input  logic [ntfp_pkg::TAG_IN_W-1:0] s_tag_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output ntfp_pkg::ntfp_res_t           m_res_o
);
  import ntfp_pkg::*;

  localparam int IDX_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W    = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;
  localparam int LIMX_W   = (CNT_W > LIM_W) ? CNT_W : LIM_W;
  localparam int ST_TAG_W = (TAG_BITS < TAG_IN_W) ? TAG_BITS : TAG_IN_W;
  localparam int ENT_W    = TS_W + ST_TAG_W;
  localparam int RAM_DEPTH = 2 * (2 ** IDX_W);
  localparam int RADDR_W  = IDX_W + 1;

  localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
  localparam logic [SUM_W-1:0]  DEPTH_SUM = SUM_W'(QUEUE_DEPTH);
  localparam logic [LIMX_W-1:0] DEPTH_LIM = LIMX_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0]  ONE_CNT   = CNT_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_SCAN,
    ST_CHECK,
    ST_CAPTURE,
    ST_SHIFT
  } state_e;

  // circular offset add, base < depth and off <= depth
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= DEPTH_SUM) begin
      sum = sum - DEPTH_SUM;
    end
    return sum[IDX_W-1:0];
  endfunction

  state_e              state_q, state_d;
  logic                dep_q, dep_d;
  logic [TS_W-1:0]     ts_q, ts_d;
  logic [ST_TAG_W-1:0] tag_q, tag_d;
  logic [IDX_W-1:0]    rgb_head_q, rgb_head_d, dep_head_q, dep_head_d;
  logic [CNT_W-1:0]    rgb_cnt_q, rgb_cnt_d, dep_cnt_q, dep_cnt_d;
  logic [CNT_W-1:0]    rd_q, rd_d;
  logic                s1_v_q, s1_v_d, s2_v_q, s2_v_d;
  logic [CNT_W-1:0]    s1_i_q, s1_i_d, s2_i_q, s2_i_d;
  logic [TS_W-1:0]     best_gap_q, best_gap_d;
  logic [CNT_W-1:0]    best_i_q, best_i_d;
  logic                best_pos_q, best_pos_d;
  logic                m_valid_q, m_valid_d;
  ntfp_res_t           res_q, res_d;

  // own queue = source of the pending frame, other = the opposite source
  logic [IDX_W-1:0]  own_head, oth_head, head_a, head_n;
  logic [CNT_W-1:0]  own_cnt, oth_cnt, cnt_a, cnt_n, lim_eff, drop, wr_off;
  logic [LIMX_W-1:0] lim_x;
  logic              full, trim;

  logic               ram_we, ram_re;
  logic [RADDR_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0]   ram_wdata, ram_rdata;
  logic [TS_W-1:0]    gap;
  logic               ts_ge;

  logic [TS_W-1:0]     oth_ts;
  logic [ST_TAG_W-1:0] oth_tag;
  logic [DELTA_W-1:0]  mag;

  assign own_head = dep_q ? dep_head_q : rgb_head_q;
  assign own_cnt  = dep_q ? dep_cnt_q  : rgb_cnt_q;
  assign oth_head = dep_q ? rgb_head_q : dep_head_q;
  assign oth_cnt  = dep_q ? rgb_cnt_q  : dep_cnt_q;

  assign lim_x   = LIMX_W'(cfg_i.limit);
  assign lim_eff = (lim_x > DEPTH_LIM) ? DEPTH_CNT : lim_x[CNT_W-1:0];

  // append: a full queue overwrites its oldest slot
  assign full   = (own_cnt == DEPTH_CNT);
  assign wr_off = full ? '0 : own_cnt;
  assign head_a = full ? wrap_add(own_head, ONE_CNT) : own_head;
  assign cnt_a  = full ? DEPTH_CNT : own_cnt + ONE_CNT;
  assign trim   = (cnt_a > lim_eff);
  assign drop   = cnt_a - lim_eff;
  assign head_n = trim ? wrap_add(head_a, drop) : head_a;
  assign cnt_n  = trim ? lim_eff : cnt_a;

  assign oth_ts  = ram_rdata[TS_W-1:0];
  assign oth_tag = ram_rdata[ENT_W-1:TS_W];
  assign mag     = best_gap_q[DELTA_W-1:0];

  ntfp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ntfp_gap_unit u_gap (
    .clk_i    (clk_i),
    .a_i      (ts_q),
    .b_i      (oth_ts),
    .gap_o    (gap),
    .a_ge_b_o (ts_ge)
  );

  always_comb begin
    state_d    = state_q;
    dep_d      = dep_q;
    ts_d       = ts_q;
    tag_d      = tag_q;
    rgb_head_d = rgb_head_q;
    rgb_cnt_d  = rgb_cnt_q;
    dep_head_d = dep_head_q;
    dep_cnt_d  = dep_cnt_q;
    rd_d       = rd_q;
    s1_v_d     = 1'b0;
    s1_i_d     = s1_i_q;
    s2_v_d     = s1_v_q;
    s2_i_d     = s1_i_q;
    best_gap_d = best_gap_q;
    best_i_d   = best_i_q;
    best_pos_d = best_pos_q;
    m_valid_d  = m_valid_q & ~m_ready_i;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_waddr  = {dep_q, wrap_add(own_head, wr_off)};
    ram_wdata  = {tag_q, ts_q};
    ram_re     = 1'b0;
    ram_raddr  = {~dep_q, wrap_add(oth_head, rd_q)};

    unique case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          if (s_cmd_i == CMD_CLEAR) begin
            rgb_head_d = '0;
            rgb_cnt_d  = '0;
            dep_head_d = '0;
            dep_cnt_d  = '0;
          end else begin
            dep_d   = s_is_depth_i;
            ts_d    = s_ts_i;
            tag_d   = s_tag_i[ST_TAG_W-1:0];
            state_d = ST_APPEND;
          end
        end
      end
      ST_APPEND: begin
        ram_we = 1'b1;
        rd_d   = '0;
        if (dep_q) begin
          dep_head_d = head_n;
          dep_cnt_d  = cnt_n;
        end else begin
          rgb_head_d = head_n;
          rgb_cnt_d  = cnt_n;
        end
        state_d = (cnt_n == '0 || oth_cnt == '0) ? ST_IDLE : ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_q < oth_cnt) begin
          ram_re = 1'b1;
          rd_d   = rd_q + ONE_CNT;
          s1_v_d = 1'b1;
          s1_i_d = rd_q;
        end
        // strict compare from oldest keeps the oldest on a tie
        if (s2_v_q && (s2_i_q == '0 || gap < best_gap_q)) begin
          best_gap_d = gap;
          best_i_d   = s2_i_q;
          best_pos_d = ts_ge ^ dep_q;
        end
        if (rd_q == oth_cnt && !s1_v_q && !s2_v_q) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ram_re    = 1'b1;
        ram_raddr = {~dep_q, wrap_add(oth_head, best_i_q)};
        state_d   = (best_gap_q > TS_W'(cfg_i.threshold)) ? ST_IDLE : ST_CAPTURE;
      end
      ST_CAPTURE: begin
        if (!m_valid_q || m_ready_i) begin
          if (dep_q) begin
            res_d.rgb_ts  = oth_ts;
            res_d.rgb_tag = TAG_IN_W'(oth_tag);
            res_d.dep_ts  = ts_q;
            res_d.dep_tag = TAG_IN_W'(tag_q);
            dep_cnt_d     = dep_cnt_q - ONE_CNT;
          end else begin
            res_d.rgb_ts  = ts_q;
            res_d.rgb_tag = TAG_IN_W'(tag_q);
            res_d.dep_ts  = oth_ts;
            res_d.dep_tag = TAG_IN_W'(oth_tag);
            rgb_cnt_d     = rgb_cnt_q - ONE_CNT;
          end
          res_d.delta = best_pos_q ? $signed(mag) : $signed(DELTA_W'(0) - mag);
          m_valid_d   = 1'b1;
          rd_d        = best_i_q + ONE_CNT;
          state_d     = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        // entries after the match move down one slot
        if (rd_q < oth_cnt) begin
          ram_re = 1'b1;
          rd_d   = rd_q + ONE_CNT;
          s1_v_d = 1'b1;
          s1_i_d = rd_q;
        end
        if (s1_v_q) begin
          ram_we    = 1'b1;
          ram_waddr = {~dep_q, wrap_add(oth_head, s1_i_q - ONE_CNT)};
          ram_wdata = ram_rdata;
        end
        if (rd_q >= oth_cnt && !s1_v_q) begin
          if (dep_q) begin
            rgb_cnt_d = rgb_cnt_q - ONE_CNT;
          end else begin
            dep_cnt_d = dep_cnt_q - ONE_CNT;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      dep_q      <= 1'b0;
      ts_q       <= '0;
      tag_q      <= '0;
      rgb_head_q <= '0;
      rgb_cnt_q  <= '0;
      dep_head_q <= '0;
      dep_cnt_q  <= '0;
      rd_q       <= '0;
      s1_v_q     <= 1'b0;
      s1_i_q     <= '0;
      s2_v_q     <= 1'b0;
      s2_i_q     <= '0;
      best_gap_q <= '0;
      best_i_q   <= '0;
      best_pos_q <= 1'b0;
      m_valid_q  <= 1'b0;
      res_q      <= '0;
    end else begin
      state_q    <= state_d;
      dep_q      <= dep_d;
      ts_q       <= ts_d;
      tag_q      <= tag_d;
      rgb_head_q <= rgb_head_d;
      rgb_cnt_q  <= rgb_cnt_d;
      dep_head_q <= dep_head_d;
      dep_cnt_q  <= dep_cnt_d;
      rd_q       <= rd_d;
      s1_v_q     <= s1_v_d;
      s1_i_q     <= s1_i_d;
      s2_v_q     <= s2_v_d;
      s2_i_q     <= s2_i_d;
      best_gap_q <= best_gap_d;
      best_i_q   <= best_i_d;
      best_pos_q <= best_pos_d;
      m_valid_q  <= m_valid_d;
      res_q      <= res_d;
    end
  end

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = m_valid_q;
  assign m_res_o   = res_q;

  `NTFP_ASSERT(a_cnt_bound, rgb_cnt_q <= DEPTH_CNT && dep_cnt_q <= DEPTH_CNT, "queue count above depth")
  `NTFP_ASSERT_IMP(a_idle_pipe, state_q == ST_IDLE, !s1_v_q && !s2_v_q, "read pipe busy while idle")
  `NTFP_ASSERT_IMP(a_emit_src, $rose(m_valid_q), $past(state_q) == ST_CAPTURE, "pair emitted outside capture")
  `NTFP_ASSERT_NXT(a_clear, s_valid_i && s_ready_o && s_cmd_i == CMD_CLEAR, rgb_cnt_q == '0 && dep_cnt_q == '0, "clear left entries")

endmodule

/* rtl/core/nearest_timestamp_frame_pairer.sv */
// ----------------------------------------------------------------------------
// nearest_timestamp_frame_pairer
// Push: tready low while the frame is appended, the other queue scanned, the best
// gap checked, and with a pair through capture, the m_axis_tready wait and shift.
// A pair reaches the output register in the capture state, after the check.
// Clear keeps tready high; a push that meets an empty queue drops it for append only.
// Rate is set by the single RAM read port and the shared gap unit, one entry a cycle.
// Reset clears queue counts and pointers and loads the register reset values.
// ----------------------------------------------------------------------------
module nearest_timestamp_frame_pairer #(
  parameter int QUEUE_DEPTH = ntfp_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = ntfp_pkg::TAG_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ntfp_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [ntfp_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [ntfp_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  // frame requests
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [63:0] frame_timestamp, [79:64] frame_tag
  input  logic [ntfp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] cmd, [1] is_depth
  input  logic [ntfp_pkg::S_TUSER_W-1:0]   s_axis_tuser,
  // pairs
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [63:0] rgb_timestamp, [79:64] rgb_tag, [143:80] depth_timestamp,
  // [159:144] depth_tag, [192:160] pair_delta, [199:193] zero
  output logic [ntfp_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
  import ntfp_pkg::*;

  logic [THR_W-1:0] thr_q;
  logic [LIM_W-1:0] lim_q;
  logic             wr_en;
  ntfp_cfg_t        cfg;
  ntfp_res_t        res;

  // register index sits at paddr[2]; byte offset bits are ignored
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      lim_q <= LIM_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_THRESHOLD: thr_q <= pwdata[THR_W-1:0];
        REG_LIMIT:     lim_q <= pwdata[LIM_W-1:0];
        default:       thr_q <= thr_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD: prdata = APB_DATA_W'(thr_q);
      REG_LIMIT:     prdata = APB_DATA_W'(lim_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg.threshold = thr_q;
  assign cfg.limit     = lim_q;

  // sequencer: append and trim, nearest scan, emit, compaction
  ntfp_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_cmd_i      (s_axis_tuser[0]),
    .s_is_depth_i (s_axis_tuser[1]),
    .s_ts_i       (s_axis_tdata[TS_W-1:0]),
    .s_tag_i      (s_axis_tdata[TS_W +: TAG_IN_W]),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_res_o      (res)
  );

  // struct packs rgb_ts in the low bits, delta on top
  assign m_axis_tdata = M_TDATA_W'(res);

endmodule
